// ===== rtl/core/six_channel_symmetric_fir_unit_macros.svh =====
// Assertion macros shared by the smoothing filter RTL.
`ifndef SIX_CHANNEL_SYMMETRIC_FIR_UNIT_MACROS_SVH
`define SIX_CHANNEL_SYMMETRIC_FIR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define SCSFIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define SCSFIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scsfir_pkg.sv =====
// Shared constants, types and register indexes of the six channel smoothing filter.
package scsfir_pkg;

  localparam int WEIGHT_BITS_DEFAULT = 16;
  localparam int SAMPLE_BITS_DEFAULT = 8;

  localparam int TAPS        = 10;
  localparam int CHANNELS    = 6;
  localparam int NUM_WEIGHTS = TAPS / 2;

  localparam int INDEX_BITS = 3;

  localparam logic [INDEX_BITS-1:0] REG_WEIGHT_OUTER  = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_WEIGHT_SECOND = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_WEIGHT_THIRD  = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_WEIGHT_FOURTH = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_WEIGHT_CENTER = 3'd4;

  // Reset weights, outermost tap pair first, in Q0.16.
  localparam logic [31:0] WEIGHT_RESET [NUM_WEIGHTS] = '{
    32'd144, 32'd1140, 32'd4830, 32'd10892, 32'd15761
  };

  typedef struct packed {
    logic shift;      // shift a new sample into the delay line
    logic load_prod;  // capture the weighted tap pairs
    logic load_out;   // capture the final filtered value
  } scsfir_ctrl_t;

endpackage

// ===== rtl/core/scsfir_in_if.sv =====
// Input channel: one frame of six raw tracking samples.
interface scsfir_in_if #(
  parameter int SAMPLE_BITS = scsfir_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] size_in;
  logic [SAMPLE_BITS-1:0] zrot_in;
  logic [SAMPLE_BITS-1:0] yrot_in;
  logic [SAMPLE_BITS-1:0] xpos_in;
  logic [SAMPLE_BITS-1:0] ypos_in;
  logic [SAMPLE_BITS-1:0] mouth_in;

  modport source (
    output valid, size_in, zrot_in, yrot_in, xpos_in, ypos_in, mouth_in,
    input  ready
  );
  modport sink (
    input  valid, size_in, zrot_in, yrot_in, xpos_in, ypos_in, mouth_in,
    output ready
  );
endinterface

// ===== rtl/core/scsfir_out_if.sv =====
// Output channel: one frame of six filtered tracking values.
interface scsfir_out_if #(
  parameter int SAMPLE_BITS = scsfir_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] size_out;
  logic [SAMPLE_BITS-1:0] zrot_out;
  logic [SAMPLE_BITS-1:0] yrot_out;
  logic [SAMPLE_BITS-1:0] xpos_out;
  logic [SAMPLE_BITS-1:0] ypos_out;
  logic [SAMPLE_BITS-1:0] mouth_out;

  modport source (
    output valid, size_out, zrot_out, yrot_out, xpos_out, ypos_out, mouth_out,
    input  ready
  );
  modport sink (
    input  valid, size_out, zrot_out, yrot_out, xpos_out, ypos_out, mouth_out,
    output ready
  );
endinterface

// ===== rtl/core/scsfir_weights.sv =====
// Register bank holding the five shared filter weights.
module scsfir_weights #(
  parameter int WEIGHT_BITS = scsfir_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [scsfir_pkg::INDEX_BITS-1:0]  wr_index,
  input  logic [WEIGHT_BITS-1:0]             wr_data,
  output logic [WEIGHT_BITS-1:0]             weights [scsfir_pkg::NUM_WEIGHTS]
);
  import scsfir_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weights[i] <= WEIGHT_BITS'(WEIGHT_RESET[i]);
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_WEIGHT_OUTER:  weights[0] <= wr_data;
        REG_WEIGHT_SECOND: weights[1] <= wr_data;
        REG_WEIGHT_THIRD:  weights[2] <= wr_data;
        REG_WEIGHT_FOURTH: weights[3] <= wr_data;
        REG_WEIGHT_CENTER: weights[4] <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/scsfir_channel.sv =====
// One channel: delay line, weighted tap pairs and the final sum with saturation.
module scsfir_channel #(
  parameter int WEIGHT_BITS = scsfir_pkg::WEIGHT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = scsfir_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  scsfir_pkg::scsfir_ctrl_t  ctrl,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic [WEIGHT_BITS-1:0]    weights [scsfir_pkg::NUM_WEIGHTS],
  output logic [SAMPLE_BITS-1:0]    result
);
  import scsfir_pkg::*;

  localparam int PAIR_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = PAIR_BITS + WEIGHT_BITS;
  localparam int SUM_BITS    = PROD_BITS + 3;
  localparam int SCALED_BITS = SUM_BITS - WEIGHT_BITS;

  logic [SAMPLE_BITS-1:0] history [TAPS];
  logic [PAIR_BITS-1:0]   pair    [NUM_WEIGHTS];
  logic [PROD_BITS-1:0]   prod    [NUM_WEIGHTS];
  logic [SUM_BITS-1:0]    acc;
  logic [SCALED_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0] result_next;

  // Entry 0 holds the newest sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        history[i] <= '0;
      end
    end else if (ctrl.shift) begin
      history[0] <= sample;
      for (int i = 1; i < TAPS; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      pair[i] = PAIR_BITS'(history[i]) + PAIR_BITS'(history[TAPS-1-i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        prod[i] <= PROD_BITS'(pair[i]) * PROD_BITS'(weights[i]);
      end
    end
  end

  // All terms are non-negative, so dropping the fraction truncates toward zero.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      acc = acc + SUM_BITS'(prod[i]);
    end
    scaled = acc[SUM_BITS-1:WEIGHT_BITS];
    if (scaled[SCALED_BITS-1:SAMPLE_BITS] != '0) begin
      result_next = '1;
    end else begin
      result_next = scaled[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/six_channel_symmetric_fir_unit.sv =====
// Six channel symmetric 10-tap smoothing filter, top level.
//
// in_ch carries one frame of six unsigned tracking samples per transaction;
// out_ch returns one frame of six filtered values for every input transaction,
// in order. The five shared Q0.WEIGHT_BITS weights are written through
// wr_en / wr_index / wr_data; a write to an index above four is ignored.
// Write weights only while no frame is in flight.
//
// An accepted frame passes the product and output registers to out_ch.
// Throughput: one frame per cycle unless out_ch stalls, set by the three-stage
// pipeline of delay line, product registers and output register, each holding
// one frame. When out_ch stalls, the stages fill up behind it and in_ch.ready
// drops once all three hold a frame; up to three frames are buffered.
//
// Reset (rst, synchronous, active high) clears every delay line to zero,
// loads the default weights and empties the pipeline.
module six_channel_symmetric_fir_unit #(
  parameter int WEIGHT_BITS = scsfir_pkg::WEIGHT_BITS_DEFAULT,
  parameter int SAMPLE_BITS = scsfir_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  scsfir_in_if.sink                         in_ch,
  scsfir_out_if.source                      out_ch,
  input  logic                              wr_en,
  input  logic [scsfir_pkg::INDEX_BITS-1:0] wr_index,
  input  logic [WEIGHT_BITS-1:0]            wr_data
);
  import scsfir_pkg::*;

  `include "six_channel_symmetric_fir_unit_macros.svh"

  logic [WEIGHT_BITS-1:0] weights [NUM_WEIGHTS];
  logic [SAMPLE_BITS-1:0] samples [CHANNELS];
  logic [SAMPLE_BITS-1:0] results [CHANNELS];
  scsfir_ctrl_t           ctrl;

  logic hist_valid;
  logic prod_valid;
  logic out_valid;
  logic out_adv;
  logic prod_adv;
  logic hist_adv;
  logic accept;

  // Each stage moves on when the one after it is empty or moving.
  assign out_adv  = !out_valid || out_ch.ready;
  assign prod_adv = !prod_valid || out_adv;
  assign hist_adv = !hist_valid || prod_adv;
  assign accept   = in_ch.valid && hist_adv;

  assign in_ch.ready    = hist_adv;
  assign out_ch.valid   = out_valid;
  assign ctrl.shift     = accept;
  assign ctrl.load_prod = hist_valid && prod_adv;
  assign ctrl.load_out  = prod_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (hist_adv) begin
        hist_valid <= in_ch.valid;
      end
      if (prod_adv) begin
        prod_valid <= hist_valid;
      end
      if (out_adv) begin
        out_valid <= prod_valid;
      end
    end
  end

  scsfir_weights #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_weights (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .weights  (weights)
  );

  assign samples[0] = in_ch.size_in;
  assign samples[1] = in_ch.zrot_in;
  assign samples[2] = in_ch.yrot_in;
  assign samples[3] = in_ch.xpos_in;
  assign samples[4] = in_ch.ypos_in;
  assign samples[5] = in_ch.mouth_in;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_channel
    scsfir_channel #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_channel (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sample  (samples[ch]),
      .weights (weights),
      .result  (results[ch])
    );
  end

  assign out_ch.size_out  = results[0];
  assign out_ch.zrot_out  = results[1];
  assign out_ch.yrot_out  = results[2];
  assign out_ch.xpos_out  = results[3];
  assign out_ch.ypos_out  = results[4];
  assign out_ch.mouth_out = results[5];

  `SCSFIR_ASSERT_NEXT(a_accept_fills_hist, in_ch.valid && in_ch.ready, hist_valid,
    "accepted frame did not reach the delay line stage")
  `SCSFIR_ASSERT_NEXT(a_hist_holds, hist_valid && !prod_adv, hist_valid,
    "stalled delay line stage lost its frame")
  `SCSFIR_ASSERT_NEXT(a_prod_holds, prod_valid && !out_adv, prod_valid,
    "stalled product stage lost its frame")
  `SCSFIR_ASSERT_NEXT(a_prod_to_out, prod_valid && out_adv, out_ch.valid,
    "product stage advanced without producing a result")
  `SCSFIR_ASSERT_NOW(a_full_blocks_input, hist_valid && prod_valid && out_valid && !out_ch.ready,
    !in_ch.ready, "input accepted while every stage was full and stalled")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the six channel symmetric smoothing filter.
`timescale 1ns / 1ps

module testbench;
  import scsfir_pkg::*;

  localparam int WEIGHT_BITS = WEIGHT_BITS_DEFAULT;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int BLOCKS_PER_PHASE = 6;
  localparam int FRAMES_PER_BLOCK = 105;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;
  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] weight_set_t;

  typedef enum int {CH_SIZE, CH_ZROT, CH_YROT, CH_XPOS, CH_YPOS, CH_MOUTH} channel_t;

  typedef enum logic [2:0] {
    WM_RESET, WM_MAX, WM_ZERO, WM_SCALED, WM_RANDOM, WM_EXTREME
  } weight_mode_t;

  typedef struct packed {
    weight_mode_t mode;
    logic         typed;
    sample_t      want;
    frame_t       frame;
  } stim_row_t;

  localparam logic [INDEX_BITS-1:0] WEIGHT_REG [NUM_WEIGHTS] = '{
    REG_WEIGHT_OUTER, REG_WEIGHT_SECOND, REG_WEIGHT_THIRD, REG_WEIGHT_FOURTH,
    REG_WEIGHT_CENTER
  };
  localparam logic [INDEX_BITS-1:0] REG_UNMAPPED [3] = '{3'd5, 3'd6, 3'd7};

  localparam weight_mode_t BLOCK_PLAN [BLOCKS_PER_PHASE] = '{
    WM_RESET, WM_SCALED, WM_RANDOM, WM_EXTREME, WM_SCALED, WM_RANDOM
  };

  // A full line of 255 under the reset weights gives 254, since twice the
  // weight sum falls just short of unity. With every weight at full scale the
  // output saturates; with every weight at zero it stays at zero.
  localparam stim_row_t DIRECTED [18] = '{
    '{WM_RESET, 1'b1, 8'd0,   {CHANNELS{8'h00}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b1, 8'd254, {CHANNELS{8'hff}}},
    '{WM_RESET, 1'b0, 8'd0,   48'h01_80_7f_fe_55_aa},
    '{WM_RESET, 1'b0, 8'd0,   48'hfe_7f_80_01_aa_55},
    '{WM_RESET, 1'b0, 8'd0,   48'h00_ff_00_ff_00_ff},
    '{WM_MAX,   1'b1, 8'd255, {CHANNELS{8'hff}}},
    '{WM_MAX,   1'b0, 8'd0,   {CHANNELS{8'h00}}},
    '{WM_ZERO,  1'b1, 8'd0,   {CHANNELS{8'hff}}},
    '{WM_ZERO,  1'b1, 8'd0,   48'h5a_a5_c3_3c_0f_f0}
  };

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [INDEX_BITS-1:0]  wr_index;
  logic [WEIGHT_BITS-1:0] wr_data;

  scsfir_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  scsfir_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  six_channel_symmetric_fir_unit #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if),
    .out_ch(out_if),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  string CH_NAME [CHANNELS] = '{"size", "zrot", "yrot", "xpos", "ypos", "mouth"};

  // Local copy of the filter state.
  sample_t              tap_history [CHANNELS][TAPS];
  logic [WEIGHT_BITS-1:0] weight_now [NUM_WEIGHTS];
  frame_t               filtered_q [$];

  int      errors = 0;
  int      stall_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    row_typed = 1'b0;
  sample_t row_want = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic frame_t filter_frame(input frame_t raw);
    frame_t      result;
    logic [33:0] acc;
    logic [33:0] level;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int t = TAPS - 1; t > 0; t--)
        tap_history[ch][t] = tap_history[ch][t-1];
      tap_history[ch][0] = raw[ch];
      acc = '0;
      for (int k = 0; k < NUM_WEIGHTS; k++)
        acc += weight_now[k] * (34'(tap_history[ch][k]) + 34'(tap_history[ch][TAPS-1-k]));
      level = acc >> WEIGHT_BITS;
      result[ch] = (level > 34'(SAMPLE_MAX)) ? SAMPLE_MAX : level[SAMPLE_BITS-1:0];
    end
    return result;
  endfunction

  function automatic weight_set_t weights_for(input weight_mode_t mode);
    weight_set_t ws;
    for (int k = 0; k < NUM_WEIGHTS; k++) begin
      case (mode)
        WM_RESET:   ws[k] = WEIGHT_RESET[k][WEIGHT_BITS-1:0];
        WM_MAX:     ws[k] = '1;
        WM_ZERO:    ws[k] = '0;
        // Twice the sum stays below unity, so outputs cover the whole range.
        WM_SCALED:  ws[k] = WEIGHT_BITS'($urandom_range(0, 6553));
        WM_EXTREME: ws[k] = $urandom_range(0, 1) ? '1 : '0;
        default:    ws[k] = WEIGHT_BITS'($urandom);
      endcase
    end
    return ws;
  endfunction

  // Half drift slowly like real tracking data; the rest are uniform or rail.
  function automatic frame_t random_frame(input frame_t prev);
    frame_t f;
    int     pick;
    int     level;
    pick = $urandom_range(0, 9);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (pick < 4) begin
        f[ch] = sample_t'($urandom);
      end else if (pick == 4) begin
        f[ch] = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      end else begin
        level = int'(prev[ch]) + int'($urandom_range(0, 16)) - 8;
        if (level < 0)
          level = 0;
        else if (level > int'(SAMPLE_MAX))
          level = int'(SAMPLE_MAX);
        f[ch] = sample_t'(level);
      end
    end
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input logic typed, input sample_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.size_in  = f[CH_SIZE];
    in_if.zrot_in  = f[CH_ZROT];
    in_if.yrot_in  = f[CH_YROT];
    in_if.xpos_in  = f[CH_XPOS];
    in_if.ypos_in  = f[CH_YPOS];
    in_if.mouth_in = f[CH_MOUTH];
    row_typed = typed;
    row_want = want;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (filtered_q.size() != 0)
      @(negedge clk);
  endtask

  // Writes happen only with the pipeline empty. The unmapped indexes get
  // nonzero junk that must not land anywhere.
  task automatic load_weights(input weight_set_t ws);
    wait_drained();
    wr_en = 1'b1;
    for (int k = 0; k < NUM_WEIGHTS; k++) begin
      wr_index = WEIGHT_REG[k];
      wr_data = ws[k];
      @(negedge clk);
    end
    for (int k = 0; k < 3; k++) begin
      wr_index = REG_UNMAPPED[k];
      wr_data = WEIGHT_BITS'($urandom_range(1, 16'hffff));
      @(negedge clk);
    end
    wr_en = 1'b0;
  endtask

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check
    frame_t got;
    frame_t want;
    if (rst) begin
      for (int ch = 0; ch < CHANNELS; ch++)
        for (int t = 0; t < TAPS; t++)
          tap_history[ch][t] = '0;
      for (int k = 0; k < NUM_WEIGHTS; k++)
        weight_now[k] = WEIGHT_RESET[k][WEIGHT_BITS-1:0];
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_WEIGHT_OUTER:  weight_now[0] = wr_data;
          REG_WEIGHT_SECOND: weight_now[1] = wr_data;
          REG_WEIGHT_THIRD:  weight_now[2] = wr_data;
          REG_WEIGHT_FOURTH: weight_now[3] = wr_data;
          REG_WEIGHT_CENTER: weight_now[4] = wr_data;
          default: ;
        endcase
      end
      // Results are checked before this edge's input is predicted, so a
      // result can never match the transaction that arrives with it.
      if (out_if.valid && out_if.ready) begin
        got[CH_SIZE]  = out_if.size_out;
        got[CH_ZROT]  = out_if.zrot_out;
        got[CH_YROT]  = out_if.yrot_out;
        got[CH_XPOS]  = out_if.xpos_out;
        got[CH_YPOS]  = out_if.ypos_out;
        got[CH_MOUTH] = out_if.mouth_out;
        if (filtered_q.size() == 0) begin
          report_mismatch("output transaction with no input outstanding");
        end else begin
          want = filtered_q.pop_front();
          for (int ch = 0; ch < CHANNELS; ch++)
            if (got[ch] !== want[ch])
              report_mismatch($sformatf("%s_out is %0d, expected %0d",
                                        CH_NAME[ch], got[ch], want[ch]));
        end
      end
      if (in_if.valid && in_if.ready) begin
        got[CH_SIZE]  = in_if.size_in;
        got[CH_ZROT]  = in_if.zrot_in;
        got[CH_YROT]  = in_if.yrot_in;
        got[CH_XPOS]  = in_if.xpos_in;
        got[CH_YPOS]  = in_if.ypos_in;
        got[CH_MOUTH] = in_if.mouth_in;
        want = filter_frame(got);
        if (row_typed)
          want = {CHANNELS{row_want}};
        filtered_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || wr_en || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t       last;
    weight_mode_t active;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_if.valid = 1'b0;
    in_if.size_in = '0;
    in_if.zrot_in = '0;
    in_if.yrot_in = '0;
    in_if.xpos_in = '0;
    in_if.ypos_in = '0;
    in_if.mouth_in = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 46;
    active = WM_RESET;
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].mode != active) begin
        active = DIRECTED[r].mode;
        load_weights(weights_for(active));
      end
      send_frame(DIRECTED[r].frame, DIRECTED[r].typed, DIRECTED[r].want);
    end

    last = '0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 6 : 0;
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        load_weights(weights_for(BLOCK_PLAN[blk]));
        for (int n = 0; n < FRAMES_PER_BLOCK; n++) begin
          // Let the pipeline run dry once per phase in the middle of a block.
          if (blk == 1 && n == FRAMES_PER_BLOCK / 2)
            wait_drained();
          last = random_frame(last);
          send_frame(last, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/scsfir_pkg.sv
rtl/core/scsfir_in_if.sv
rtl/core/scsfir_out_if.sv
rtl/core/scsfir_weights.sv
rtl/core/scsfir_channel.sv
rtl/core/six_channel_symmetric_fir_unit.sv
test/testbench.sv
